@@ design/sfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, codes and constants of the serial link frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 64;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [31:0] BEACON_RESET = 32'h0007_DF05;
    localparam logic        CRC_RESET    = 1'b0;

    // frame type codes, low nibble of header byte 0
    localparam logic [3:0] TYPE_BEACON   = 4'd5;
    localparam logic [3:0] TYPE_PING     = 4'd6;
    localparam logic [3:0] TYPE_SHORT_FF = 4'd15;
    localparam logic [3:0] TYPE_REQUEST  = 4'd9;
    localparam logic [3:0] TYPE_RESPONSE = 4'd10;

    localparam logic [13:0] TRAILER_BYTES = 14'd2;
    localparam logic [2:0]  VALUE_BYTES_MAX = 3'd4;

    // register index (paddr[2])
    localparam logic REG_BEACON = 1'b0;
    localparam logic REG_CRC    = 1'b1;

    typedef enum logic [2:0] {
        EV_BEACON   = 3'd0,
        EV_PING     = 3'd1,
        EV_SHORT    = 3'd2,
        EV_REQUEST  = 3'd3,
        EV_RESPONSE = 3'd4,
        EV_OVERSIZE = 3'd5
    } event_kind_t;

    typedef struct packed {
        logic [31:0] beacon_word;
        logic        crc_enabled;
    } cfg_t;

    // one classified frame event, queued between front and back
    typedef struct packed {
        event_kind_t kind;
        logic [31:0] header;
        logic        has_status;
        logic [7:0]  status;
        logic [31:0] accum;
        logic [2:0]  value_bytes;
    } evt_t;

endpackage

@@ design/sfd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_byte_if / sfd_event_if
// Valid/ready channels for received bytes and for frame events.
// ----------------------------------------------------------------------------
interface sfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [31:0] header_word;
    logic        resp_has_status;
    logic [7:0]  resp_status;
    logic [31:0] resp_value;
    logic [2:0]  resp_value_bytes;

    modport source (
        output valid, output event_kind, output header_word, output resp_has_status,
        output resp_status, output resp_value, output resp_value_bytes, input ready
    );
    modport sink (
        input valid, input event_kind, input header_word, input resp_has_status,
        input resp_status, input resp_value, input resp_value_bytes, output ready
    );
endinterface

@@ design/serial_link_frame_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_link_frame_deframer
// Splits a received byte stream into frames and reports one event per frame.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock on rx and reports frame events
// on evt. A four-byte header is gathered; its type nibble picks a short frame
// (beacon match, ping or other), a request or response body, or a resync that
// drops the oldest byte. A request is counted across its body; a response
// reports its last payload byte as status and up to four leading data bytes,
// little endian. A length that would overrun MAX_FRAME_BYTES is reported at
// once and the header is resynchronised. With crc_enabled set, two trailer
// bytes follow each long payload and are skipped unchecked. Rate: one byte
// per cycle while the event queue has room. The byte intake decides each
// byte combinationally and writes any event into a two-entry event queue at
// the same edge; the result register takes the event from the queue once it
// is free and holds it on evt until taken. rx stalls only while the queue
// is full, that is while the sink leaves results untaken. There is no
// clearing pass after reset. Registers (APB, 32-bit): 0x0 beacon_word,
// 0x4 crc_enabled; write them only while no frame is in progress.
// ----------------------------------------------------------------------------
module serial_link_frame_deframer #(
    parameter int MAX_FRAME_BYTES = sfd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    sfd_byte_if.sink     rx,
    sfd_event_if.source  evt,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [31:0]    beacon_word_reg;
    logic           crc_enabled_reg;
    logic           cfg_write;
    sfd_pkg::cfg_t  cfg;
    logic           q_full;
    logic           q_empty;
    logic           push;
    logic           pop;
    sfd_pkg::evt_t  push_data;
    sfd_pkg::evt_t  head;

    // Configuration port: no wait states, write in the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beacon_word_reg <= sfd_pkg::BEACON_RESET;
            crc_enabled_reg <= sfd_pkg::CRC_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                sfd_pkg::REG_BEACON: beacon_word_reg <= pwdata;
                sfd_pkg::REG_CRC:    crc_enabled_reg <= pwdata[0];
                default:             crc_enabled_reg <= crc_enabled_reg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (paddr[2])
            sfd_pkg::REG_BEACON: prdata = beacon_word_reg;
            sfd_pkg::REG_CRC:    prdata = {31'd0, crc_enabled_reg};
            default:             prdata = '0;
        endcase
    end

    assign cfg.beacon_word = beacon_word_reg;
    assign cfg.crc_enabled = crc_enabled_reg;

    // Front: gather header, classify, track the body
    sfd_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cfg       (cfg),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // Decouple: the front keeps taking bytes while the sink stalls, until the queue is full
    sfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .pop_data  (head)
    );

    // Back: trim the value and hold the result until taken
    sfd_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (q_empty),
        .head  (head),
        .pop   (pop),
        .evt   (evt)
    );

endmodule

@@ design/sfd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_front
// Byte intake: collect the header, classify it and track the frame body.
// ----------------------------------------------------------------------------
module sfd_front #(
    parameter int MAX_FRAME_BYTES = sfd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    sfd_byte_if.sink       rx,
    input  sfd_pkg::cfg_t  cfg,
    input  logic           q_full,
    output logic           push,
    output sfd_pkg::evt_t  push_data
);

    localparam logic [13:0] BODY_LIMIT = 14'(MAX_FRAME_BYTES - 4);

    typedef enum logic [1:0] {
        FRAME_NONE = 2'd0,
        FRAME_REQ  = 2'd1,
        FRAME_RESP = 2'd2
    } frame_t;

    frame_t        frame_reg,  frame_next;
    logic [31:0]   window_reg, window_next;
    logic [2:0]    fill_reg,   fill_next;
    logic [6:0]    left_reg,   left_next;
    logic [6:0]    seen_reg,   seen_next;
    logic [31:0]   accum_reg,  accum_next;
    logic [7:0]    last_reg,   last_next;
    logic          accept;

    assign rx.ready = !q_full;
    assign accept   = rx.valid && !q_full;

    always_comb
    begin
        logic [31:0] win;
        logic [12:0] plen;
        logic [13:0] body;
        logic [3:0]  ftype;
        logic [6:0]  left;
        logic        close;

        frame_next  = frame_reg;
        window_next = window_reg;
        fill_next   = fill_reg;
        left_next   = left_reg;
        seen_next   = seen_reg;
        accum_next  = accum_reg;
        last_next   = last_reg;
        push        = 1'b0;
        push_data   = '0;
        close       = 1'b0;
        win         = window_reg | ({24'd0, rx.rx_byte} << {fill_reg[1:0], 3'b000});
        plen        = window_reg[16:4];
        ftype       = win[3:0];
        body        = {1'b0, win[16:4]} + (cfg.crc_enabled ? sfd_pkg::TRAILER_BYTES : 14'd0);
        left        = left_reg - 7'd1;

        if (accept)
        begin
            if (frame_reg != FRAME_NONE)
            begin
                // body byte: payload first, then trailer
                if ({6'd0, seen_reg} < plen)
                begin
                    last_next = rx.rx_byte;
                    if (seen_reg < 7'd4)
                    begin
                        accum_next = accum_reg
                                   | ({24'd0, rx.rx_byte} << {seen_reg[1:0], 3'b000});
                    end
                    seen_next = seen_reg + 7'd1;
                end
                left_next = left;
                close     = (left == 7'd0);
            end
            else
            begin
                window_next = win;
                fill_next   = fill_reg + 3'd1;
                if (fill_next >= 3'd4)
                begin
                    unique case (ftype) inside
                        sfd_pkg::TYPE_BEACON, sfd_pkg::TYPE_PING, sfd_pkg::TYPE_SHORT_FF:
                        begin
                            push           = 1'b1;
                            push_data.header = win;
                            if (win == cfg.beacon_word)
                                push_data.kind = sfd_pkg::EV_BEACON;
                            else if (ftype == sfd_pkg::TYPE_PING)
                                push_data.kind = sfd_pkg::EV_PING;
                            else
                                push_data.kind = sfd_pkg::EV_SHORT;
                            window_next = '0;
                            fill_next   = '0;
                        end
                        sfd_pkg::TYPE_REQUEST, sfd_pkg::TYPE_RESPONSE:
                        begin
                            if (body > BODY_LIMIT)
                            begin
                                // oversize: report, drop oldest byte, resync
                                push             = 1'b1;
                                push_data.kind   = sfd_pkg::EV_OVERSIZE;
                                push_data.header = win;
                                window_next      = {8'd0, win[31:8]};
                                fill_next        = 3'd3;
                            end
                            else
                            begin
                                frame_next = (ftype == sfd_pkg::TYPE_RESPONSE)
                                           ? FRAME_RESP : FRAME_REQ;
                                left_next  = body[6:0];
                                seen_next  = '0;
                                accum_next = '0;
                                last_next  = '0;
                                close      = (body == 14'd0);
                            end
                        end
                        default:
                        begin
                            // unknown type: drop oldest byte, wait for one more
                            window_next = {8'd0, win[31:8]};
                            fill_next   = 3'd3;
                        end
                    endcase
                end
            end

            if (close)
            begin
                push             = 1'b1;
                push_data.header = window_next;
                if (frame_next == FRAME_RESP)
                begin
                    push_data.kind = sfd_pkg::EV_RESPONSE;
                    if (window_next[16:4] != 13'd0)
                    begin
                        push_data.has_status  = 1'b1;
                        push_data.status      = last_next;
                        push_data.accum       = accum_next;
                        push_data.value_bytes = (window_next[16:4] > 13'd4)
                                              ? sfd_pkg::VALUE_BYTES_MAX
                                              : 3'(window_next[16:4] - 13'd1);
                    end
                end
                else
                begin
                    push_data.kind = sfd_pkg::EV_REQUEST;
                end
                frame_next  = FRAME_NONE;
                window_next = '0;
                fill_next   = '0;
                left_next   = '0;
                seen_next   = '0;
                accum_next  = '0;
                last_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg  <= FRAME_NONE;
            window_reg <= '0;
            fill_reg   <= '0;
            left_reg   <= '0;
            seen_reg   <= '0;
            accum_reg  <= '0;
            last_reg   <= '0;
        end
        else
        begin
            frame_reg  <= frame_next;
            window_reg <= window_next;
            fill_reg   <= fill_next;
            left_reg   <= left_next;
            seen_reg   <= seen_next;
            accum_reg  <= accum_next;
            last_reg   <= last_next;
        end
    end

endmodule

@@ design/sfd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_queue
// Short event queue between the byte front and the result back.
// ----------------------------------------------------------------------------
module sfd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sfd_pkg::evt_t  push_data,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output sfd_pkg::evt_t  pop_data
);

    localparam int PTR_W = (sfd_pkg::QUEUE_DEPTH > 1) ? $clog2(sfd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(sfd_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(sfd_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(sfd_pkg::QUEUE_DEPTH - 1);

    sfd_pkg::evt_t      mem [sfd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == DEPTH_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

@@ design/sfd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_back
// Result stage: trim the response value and hold the event for the sink.
// ----------------------------------------------------------------------------
module sfd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  sfd_pkg::evt_t  head,
    output logic           pop,
    sfd_event_if.source    evt
);

    logic        valid_reg;
    logic [2:0]  kind_reg;
    logic [31:0] header_reg;
    logic        has_reg;
    logic [7:0]  status_reg;
    logic [31:0] value_reg;
    logic [2:0]  nbytes_reg;
    logic [31:0] mask;
    logic        load;

    assign load = !valid_reg || evt.ready;
    assign pop  = load && !empty;

    always_comb
    begin
        case (head.value_bytes)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00FF;
            3'd2:    mask = 32'h0000_FFFF;
            3'd3:    mask = 32'h00FF_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= !empty;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg   <= head.kind;
            header_reg <= head.header;
            has_reg    <= head.has_status;
            status_reg <= head.status;
            value_reg  <= head.accum & mask;
            nbytes_reg <= head.value_bytes;
        end
    end

    assign evt.valid            = valid_reg;
    assign evt.event_kind       = kind_reg;
    assign evt.header_word      = header_reg;
    assign evt.resp_has_status  = has_reg;
    assign evt.resp_status      = status_reg;
    assign evt.resp_value       = value_reg;
    assign evt.resp_value_bytes = nbytes_reg;

endmodule

@@ design/sfd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks on the deframer's event stream, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        evt_valid,
    input logic        evt_ready,
    input logic [2:0]  event_kind,
    input logic [31:0] header_word,
    input logic        resp_has_status,
    input logic [7:0]  resp_status,
    input logic [31:0] resp_value,
    input logic [2:0]  resp_value_bytes
);

    // a stalled event holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid && $stable(event_kind)
            && $stable(header_word) && $stable(resp_value))
        else $error("event changed while stalled");

    // response fields stay clear on every other event
    a_resp_clear: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && event_kind != sfd_pkg::EV_RESPONSE |->
            !resp_has_status && resp_status == 8'd0 && resp_value == 32'd0
            && resp_value_bytes == 3'd0)
        else $error("response fields set on a non-response event");

    // value bytes bounded, and an empty response carries nothing
    a_resp_value: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && event_kind == sfd_pkg::EV_RESPONSE |->
            resp_value_bytes <= sfd_pkg::VALUE_BYTES_MAX
            && (resp_has_status || (resp_value == 32'd0 && resp_value_bytes == 3'd0)))
        else $error("response value inconsistent");

    // long frame events match their header type
    a_long_type: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (event_kind == sfd_pkg::EV_REQUEST
            || event_kind == sfd_pkg::EV_RESPONSE || event_kind == sfd_pkg::EV_OVERSIZE) |->
            header_word[3:0] == sfd_pkg::TYPE_REQUEST
            || header_word[3:0] == sfd_pkg::TYPE_RESPONSE)
        else $error("long frame event with a short header type");

    // a ping event carries a ping header
    a_ping_type: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && event_kind == sfd_pkg::EV_PING |->
            header_word[3:0] == sfd_pkg::TYPE_PING)
        else $error("ping event without ping type");

endmodule

bind serial_link_frame_deframer sfd_checker u_sfd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .evt_valid        (evt.valid),
    .evt_ready        (evt.ready),
    .event_kind       (evt.event_kind),
    .header_word      (evt.header_word),
    .resp_has_status  (evt.resp_has_status),
    .resp_status      (evt.resp_status),
    .resp_value       (evt.resp_value),
    .resp_value_bytes (evt.resp_value_bytes)
);
